[src/tmbc_pkg.sv]
// ----------------------------------------------------------------------------
// tmbc_pkg: shared types and constants for the tile map box collision block
// Register layout, reset values, item codes and the controller to datapath
// command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tmbc_pkg;

	// field widths fixed by the item layout
	localparam int CELL_IDX_W = 6;
	localparam int CODE_W     = 8;
	localparam int COORD_W    = 16;
	localparam int HALF_W     = 15;
	localparam int GRID_REG_W = 7;
	localparam int CS_W       = 15;

	// item kinds carried on tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// map code that marks a wall
	localparam logic [CODE_W-1:0] WALL_CODE = 8'd1;

	// register indexes, one word apart
	typedef enum logic [1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_CELL_SIZE  = 2'd2,
		REG_WALL_HALF  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [GRID_REG_W-1:0] map_width;
		logic [GRID_REG_W-1:0] map_height;
		logic [CS_W-1:0]       cell_size;
		logic [HALF_W-1:0]     wall_half;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		map_width:  7'd64,
		map_height: 7'd64,
		cell_size:  15'd256,
		wall_half:  15'd128
	};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_SETUP_X,
		ST_SETUP_Z,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load_item;
		logic do_write;
		logic setup_x;
		logic setup_z;
		logic scan_step;
		logic load_result;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic grid_empty;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

[src/tile_map_box_collision.sv]
// ----------------------------------------------------------------------------
// tile_map_box_collision: wall bitmap of a tile grid with box overlap query
// Input stream: tuser selects a cell write or a collision query, tdata
// carries the cell and query fields. Output stream returns one result per
// input transfer: hit for queries, write_ok for writes.
// A query's result is set by the scan through the single read port of the
// wall RAM, one cell per cycle over the effective grid; a query on an empty
// grid skips the scan. The next input transfer is taken once the previous
// result has been loaded into the output register.
// After reset a clearing sweep zeroes every entry of the wall RAM, one entry
// per cycle, 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries (4096 by default);
// no input transfer is taken meanwhile, register writes are taken as ever.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls longer, the following result waits in
// the sequencer and the input stays blocked until the register frees.
// Registers are to be written over the APB port only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_map_box_collision
	import tmbc_pkg::*;
#(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: cell_col[5:0], cell_row[11:6], cell_code[19:12], query_x[35:20],
	//        query_z[51:36], query_half[66:52], zero[71:67]
	input  wire logic [71:0] s_axis_tdata,
	// tuser: op[0]
	input  wire logic        s_axis_tuser,
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: hit[0], write_ok[1], zero[7:2]
	output logic [7:0]       m_axis_tdata,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	dp_cmd_t  cmd;
	dp_sts_t  sts;
	logic     res_hit;
	logic     res_ok;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MAP_WIDTH:  cfg_q.map_width  <= pwdata[GRID_REG_W-1:0];
				REG_MAP_HEIGHT: cfg_q.map_height <= pwdata[GRID_REG_W-1:0];
				REG_CELL_SIZE:  cfg_q.cell_size  <= pwdata[CS_W-1:0];
				REG_WALL_HALF:  cfg_q.wall_half  <= pwdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_MAP_WIDTH:  prdata = 32'(cfg_q.map_width);
			REG_MAP_HEIGHT: prdata = 32'(cfg_q.map_height);
			REG_CELL_SIZE:  prdata = 32'(cfg_q.cell_size);
			REG_WALL_HALF:  prdata = 32'(cfg_q.wall_half);
			default:        prdata = '0;
		endcase
	end

	tmbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tmbc_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.in_col       (s_axis_tdata[5:0]),
		.in_row       (s_axis_tdata[11:6]),
		.in_code      (s_axis_tdata[19:12]),
		.in_qx        (s_axis_tdata[35:20]),
		.in_qz        (s_axis_tdata[51:36]),
		.in_half      (s_axis_tdata[66:52]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_hit      (res_hit),
		.out_write_ok (res_ok)
	);

	assign m_axis_tdata = {6'b0, res_ok, res_hit};

endmodule

`default_nettype wire

[src/tmbc_ram.sv]
// ----------------------------------------------------------------------------
// tmbc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbc_ram #(
	parameter int WIDTH  = 1,
	parameter int ADDR_W = 12
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/tmbc_datapath.sv]
// ----------------------------------------------------------------------------
// tmbc_datapath: wall map store, cell scan and box overlap test
// Holds the item, the wall bitmap RAM, the scan counters with running block
// centres, the overlap compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbc_datapath
	import tmbc_pkg::*;
#(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts,
	input  wire logic [CELL_IDX_W-1:0] in_col,
	input  wire logic [CELL_IDX_W-1:0] in_row,
	input  wire logic [CODE_W-1:0]     in_code,
	input  wire logic [COORD_W-1:0]    in_qx,
	input  wire logic [COORD_W-1:0]    in_qz,
	input  wire logic [HALF_W-1:0]     in_half,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       out_hit,
	output logic                       out_write_ok
);

	// index widths and count widths
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW  = CW + RW;
	localparam int WCW = $clog2(MAX_COLS + 1);
	localparam int WRW = $clog2(MAX_ROWS + 1);
	localparam int MW  = (WCW > WRW) ? WCW : WRW;
	localparam int KW  = (MW > CELL_IDX_W) ? MW : CELL_IDX_W;
	localparam int GW  = (GRID_REG_W > MW) ? GRID_REG_W : MW;
	localparam int XW  = MW + CS_W + 1;
	localparam int DW  = XW + 2;

	// effective grid size
	logic [WCW-1:0] eff_w;
	logic [WRW-1:0] eff_h;
	logic [WCW-1:0] w_m1;
	logic [WRW-1:0] h_m1;

	always_comb begin
		eff_w = (GW'(cfg.map_width) > GW'(MAX_COLS)) ? WCW'(MAX_COLS) : WCW'(cfg.map_width);
		eff_h = (GW'(cfg.map_height) > GW'(MAX_ROWS)) ? WRW'(MAX_ROWS) : WRW'(cfg.map_height);
		w_m1  = eff_w - WCW'(1);
		h_m1  = eff_h - WRW'(1);
	end

	// item registers
	logic [CELL_IDX_W-1:0] col_in_q;
	logic [CELL_IDX_W-1:0] row_in_q;
	logic [CODE_W-1:0]     code_q;
	logic [HALF_W-1:0]     half_q;
	logic signed [DW-1:0]  qx2_q;
	logic signed [DW-1:0]  qz2_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			col_in_q <= in_col;
			row_in_q <= in_row;
			code_q   <= in_code;
			half_q   <= in_half;
			qx2_q    <= DW'($signed({in_qx, 1'b0}));
			qz2_q    <= DW'($signed({in_qz, 1'b0}));
		end
	end

	// clearing sweep counter
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// write target check
	logic          in_range;
	logic [AW-1:0] cell_addr;

	always_comb begin
		in_range  = (KW'(col_in_q) < KW'(eff_w)) && (KW'(row_in_q) < KW'(eff_h));
		cell_addr = {RW'(row_in_q), CW'(col_in_q)};
	end

	// scan counters and running block centres, doubled units
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic signed [XW-1:0]  bx2_q;
	logic signed [XW-1:0]  bz2_q;
	logic signed [XW-1:0]  bz0_q;
	logic signed [XW-1:0]  step2;
	logic [MW-1:0]         mul_a;
	logic [MW+CS_W-1:0]    prod;
	logic signed [XW-1:0]  prod_s;
	logic                  row_last;
	logic                  col_last;

	always_comb begin
		step2    = XW'({cfg.cell_size, 1'b0});
		mul_a    = cmd.setup_x ? MW'(w_m1) : MW'(h_m1);
		prod     = mul_a * cfg.cell_size;
		prod_s   = XW'(prod);
		row_last = (WRW'(row_q) == h_m1);
		col_last = (WCW'(col_q) == w_m1);
	end

	always_ff @(posedge clk) begin
		if (cmd.setup_x) begin
			bx2_q <= -prod_s;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.setup_z) begin
			bz2_q <= prod_s;
			bz0_q <= prod_s;
		end else if (cmd.scan_step) begin
			if (row_last) begin
				row_q <= '0;
				col_q <= col_q + CW'(1);
				bz2_q <= bz0_q;
				bx2_q <= bx2_q + step2;
			end else begin
				row_q <= row_q + RW'(1);
				bz2_q <= bz2_q - step2;
			end
		end
	end

	// overlap limit, doubled units
	logic [HALF_W:0]      half_sum;
	logic signed [DW-1:0] lim_q;
	logic signed [DW-1:0] nlim_q;

	assign half_sum = {1'b0, half_q} + {1'b0, cfg.wall_half};

	always_ff @(posedge clk) begin
		if (cmd.setup_x) begin
			lim_q <= DW'({half_sum, 1'b0});
		end
		if (cmd.setup_z) begin
			nlim_q <= -lim_q;
		end
	end

	// wall map RAM: sweep clear, cell write, scan read
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          wall_s1;

	always_comb begin
		ram_we    = cmd.clear_step || (cmd.do_write && in_range);
		ram_waddr = cmd.clear_step ? clr_q : cell_addr;
		ram_wdata = cmd.clear_step ? 1'b0 : (code_q == WALL_CODE);
	end

	tmbc_ram #(
		.WIDTH  (1),
		.ADDR_W (AW)
	) u_wall_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr ({row_q, col_q}),
		.rdata (wall_s1)
	);

	// distance stage, aligned with the RAM read data
	logic                 vld_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= qx2_q - DW'(bx2_q);
		dz_s1 <= qz2_q - DW'(bz2_q);
	end

	// hit accumulation and write status
	logic hit_q;
	logic ok_q;
	logic cell_hit;

	assign cell_hit = vld_s1 && wall_s1
		&& (dx_s1 < lim_q) && (dx_s1 > nlim_q)
		&& (dz_s1 < lim_q) && (dz_s1 > nlim_q);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			hit_q <= 1'b0;
			ok_q  <= 1'b0;
		end else begin
			if (cell_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.do_write) begin
				ok_q <= in_range;
			end
		end
	end

	// output register
	logic out_valid_q;
	logic out_hit_q;
	logic out_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_hit_q <= hit_q;
			out_ok_q  <= ok_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_hit      = out_hit_q;
	assign out_write_ok = out_ok_q;

	// status to the controller
	always_comb begin
		sts.clear_last = (clr_q == '1);
		sts.scan_last  = row_last && col_last;
		sts.grid_empty = (eff_w == '0) || (eff_h == '0);
		sts.out_busy   = out_valid_q && !out_ready;
	end

endmodule

`default_nettype wire

[src/tmbc_ctrl.sv]
// ----------------------------------------------------------------------------
// tmbc_ctrl: sequencer for the tile map box collision block
// Runs the clearing sweep after reset, then takes one item at a time and
// steps the datapath through write or setup, scan and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbc_ctrl
	import tmbc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_op,
	output logic         in_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = (in_op == OP_QUERY) ? ST_SETUP_X : ST_WRITE;
			end
			ST_WRITE:   state_nxt = ST_DONE;
			ST_SETUP_X: state_nxt = ST_SETUP_Z;
			ST_SETUP_Z: state_nxt = sts.grid_empty ? ST_DONE : ST_SCAN;
			ST_SCAN: begin
				if (sts.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN:   state_nxt = ST_DONE;
			ST_DONE: begin
				if (!sts.out_busy) state_nxt = ST_IDLE;
			end
			default:    state_nxt = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR:   cmd.clear_step = 1'b1;
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_WRITE:   cmd.do_write = 1'b1;
			ST_SETUP_X: cmd.setup_x = 1'b1;
			ST_SETUP_Z: cmd.setup_z = 1'b1;
			ST_SCAN:    cmd.scan_step = 1'b1;
			ST_DRAIN:   cmd = '0;
			ST_DONE:    cmd.load_result = !sts.out_busy;
			default:    cmd = '0;
		endcase
	end

	// sweep ends in idle, never in a work state
	a_clear_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && sts.clear_last) |=> (state_q == ST_IDLE))
		else $error("clearing sweep did not end in idle");

	// a query transfer always starts with setup
	a_query_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_op == OP_QUERY) |=> (state_q == ST_SETUP_X))
		else $error("query transfer did not enter setup");

	// the last scanned cell is followed by the drain cycle
	a_scan_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_last) |=> (state_q == ST_DRAIN && !cmd.scan_step))
		else $error("scan ran past the last cell");

	// an empty grid skips the scan
	a_empty_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP_Z && sts.grid_empty) |=> (state_q == ST_DONE))
		else $error("empty grid entered the scan");

endmodule

`default_nettype wire

[tb/sv/tile_map_box_collision_tb.sv]
// ----------------------------------------------------------------------------
// tile_map_box_collision_tb: self-checking bench for the tile map collision block
// Sends cell writes and box queries over the input stream and reprograms the
// grid registers over APB between phases. Every result is checked against an
// in-bench copy of the wall map and doubled-unit overlap test, or a fixed value.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_map_box_collision_tb
	import tmbc_pkg::*;
();

	localparam int GRID_COLS        = 64;
	localparam int GRID_ROWS        = 64;
	localparam int CLK_HALF         = 6;
	localparam int RESET_CYCLES     = 4;
	localparam int SETTLE_CYCLES    = 8;
	localparam int TAIL_CYCLES      = 32;
	localparam int CYCLE_LIMIT      = 1000000;
	localparam int RAND_PHASES      = 8;
	localparam int PHASE_ITEMS      = 15;
	localparam int BIG_GRID_CELLS   = 1024;
	localparam int BIG_GRID_QUERIES = 3;
	localparam int DIRECTED_STEPS   = 29;

	typedef enum logic { STEP_ITEM, STEP_REG } step_kind_t;
	typedef enum logic { CHK_MODEL, CHK_FIXED } chk_t;

	typedef struct packed {
		logic                  op;
		logic [CELL_IDX_W-1:0] col;
		logic [CELL_IDX_W-1:0] row;
		logic [CODE_W-1:0]     code;
		logic [COORD_W-1:0]    qx;
		logic [COORD_W-1:0]    qz;
		logic [HALF_W-1:0]     qhalf;
	} cell_item_t;

	typedef struct packed {
		step_kind_t  kind;
		reg_idx_t    ridx;
		logic [14:0] rval;
		cell_item_t  it;
		chk_t        chk;
		logic        hit;
		logic        wok;
	} step_t;

	typedef struct packed {
		logic hit;
		logic write_ok;
	} outcome_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// tdata: cell_col, cell_row, cell_code, query_x, query_z, query_half, zero pad
	logic [71:0] s_axis_tdata  = '0;
	// tuser: op
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tdata: hit, write_ok, zero pad
	logic [7:0]  m_axis_tdata;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [3:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the block state
	cfg_t        regs_shadow = CFG_RESET;
	logic        wall_bits [GRID_COLS*GRID_ROWS];
	outcome_t    pending_q [$];
	step_t       directed_steps [DIRECTED_STEPS];
	int          fail_count  = 0;
	int          cycle_count = 0;

	tile_map_box_collision dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #CLK_HALF clk = ~clk;

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// grid sizes above the array limit act as the limit
	function automatic int unsigned eff_dim(logic [GRID_REG_W-1:0] v, int unsigned cap);
		return (v > cap) ? cap : int'(v);
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return 16'(v);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// apply one item to the wall map shadow and work out its result
	function automatic outcome_t resolve_item(cell_item_t it);
		int unsigned w, h;
		int          c, r;
		longint      qx2, qz2, lim2, cs, bx2, bz2;
		outcome_t    res;
		res = '0;
		w = eff_dim(regs_shadow.map_width, GRID_COLS);
		h = eff_dim(regs_shadow.map_height, GRID_ROWS);
		if (it.op == OP_WRITE) begin
			if (it.col < w && it.row < h) begin
				wall_bits[int'(it.row) * GRID_COLS + int'(it.col)] = (it.code == WALL_CODE);
				res.write_ok = 1'b1;
			end
		end else begin
			// doubled units keep the half-cell centres exact
			qx2  = 2 * longint'($signed(it.qx));
			qz2  = 2 * longint'($signed(it.qz));
			lim2 = 2 * (longint'(it.qhalf) + longint'(regs_shadow.wall_half));
			cs   = longint'(regs_shadow.cell_size);
			for (c = 0; c < int'(w) && !res.hit; c++) begin
				bx2 = (2 * longint'(c) + 1 - longint'(w)) * cs;
				for (r = 0; r < int'(h) && !res.hit; r++) begin
					bz2 = -((2 * longint'(r) + 1 - longint'(h)) * cs);
					if (wall_bits[r * GRID_COLS + c] && mag(qx2 - bx2) < lim2
							&& mag(qz2 - bz2) < lim2)
						res.hit = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// APB write, then read back the same register
	task automatic program_reg(reg_idx_t idx, logic [31:0] value);
		logic [31:0] want;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_MAP_WIDTH: begin
				regs_shadow.map_width = value[GRID_REG_W-1:0];
				want = 32'(regs_shadow.map_width);
			end
			REG_MAP_HEIGHT: begin
				regs_shadow.map_height = value[GRID_REG_W-1:0];
				want = 32'(regs_shadow.map_height);
			end
			REG_CELL_SIZE: begin
				regs_shadow.cell_size = value[CS_W-1:0];
				want = 32'(regs_shadow.cell_size);
			end
			default: begin
				regs_shadow.wall_half = value[HALF_W-1:0];
				want = 32'(regs_shadow.wall_half);
			end
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$error("%s readback: expected %0d, got %0d", idx.name(), want, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// one input transfer; the expectation is queued at the accepting edge
	task automatic push_item(cell_item_t it, int gap, chk_t chk, outcome_t fixed);
		outcome_t predicted;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {5'b0, it.qhalf, it.qz, it.qx, it.code, it.row, it.col};
		s_axis_tuser  = it.op;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = resolve_item(it);
		pending_q.insert(pending_q.size(), (chk == CHK_FIXED) ? fixed : predicted);
		@(negedge clk);
	endtask

	// block is idle once every result is back and a few cycles have passed
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing pending: tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_q.pop_front();
				if (m_axis_tdata[0] !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, m_axis_tdata[0]);
					fail_count++;
				end
				if (m_axis_tdata[1] !== want.write_ok) begin
					$error("write_ok: expected %0d, got %0d", want.write_ok, m_axis_tdata[1]);
					fail_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver stalls: short ones mostly, some long, and calm stretches
	initial begin : sink_pacing
		int stall, calm, pick;
		stall = 0;
		calm  = 0;
		forever begin
			@(negedge clk);
			if (calm > 0) begin
				calm--;
				m_axis_tready = 1'b1;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 2)
					calm = $urandom_range(100, 400);
				else if (pick < 19)
					stall = $urandom_range(1, 3);
				else if (pick < 22)
					stall = $urandom_range(10, 60);
			end
		end
	end

	initial begin : stimulus
		step_t       st;
		cell_item_t  it;
		outcome_t    fixed;
		int          i, p, n, pick, queries;
		int unsigned w_reg, h_reg, cs_reg, bh_reg, ew, eh, tc, tr;
		longint      lim, cs, cx, cz;
		bit          calm, big;

		for (i = 0; i < GRID_COLS * GRID_ROWS; i++)
			wall_bits[i] = 1'b0;

		// kind, register, value, {op, col, row, code, x, z, half}, check, hit, write_ok
		directed_steps = '{
			// empty map after reset
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'd20, 16'd30, 15'd100}, CHK_FIXED, 1'b0, 1'b0},
			// grid corners and a non-wall code
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd0, 6'd0, 8'd1, 16'd0, 16'd0, 15'd0}, CHK_FIXED, 1'b0, 1'b1},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd63, 6'd63, 8'd1, 16'hFFFF, 16'hFFFF, 15'h7FFF},
				CHK_FIXED, 1'b0, 1'b1},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd12, 6'd34, 8'd254, 16'd0, 16'd0, 15'd0}, CHK_FIXED, 1'b0, 1'b1},
			// centre of cell 0,0 at -8064, +8064 with a zero half edge
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'hE080, 16'h1F80, 15'd0}, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd63, 6'd63, 8'd255, 16'h7FFF, 16'h8000, 15'h7FFF},
				CHK_MODEL, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'h8000, 16'h7FFF, 15'd0}, CHK_MODEL, 1'b0, 1'b0},
			// clearing a wall
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd63, 6'd63, 8'd0, 16'd0, 16'd0, 15'd0}, CHK_FIXED, 1'b0, 1'b1},
			'{STEP_REG, REG_MAP_WIDTH, 15'd8, '0, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_REG, REG_MAP_HEIGHT, 15'd4, '0, CHK_MODEL, 1'b0, 1'b0},
			// writes just outside the grid and at its last cell
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd8, 6'd0, 8'd1, 16'd0, 16'd0, 15'd0}, CHK_FIXED, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd0, 6'd4, 8'd1, 16'd0, 16'd0, 15'd0}, CHK_FIXED, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd7, 6'd3, 8'd1, 16'd0, 16'd0, 15'd0}, CHK_FIXED, 1'b0, 1'b1},
			// cell 7,3 of an 8 by 4 grid sits at 896, -384
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'd896, 16'hFE80, 15'd0}, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'd0, 16'd0, 15'd0}, CHK_MODEL, 1'b0, 1'b0},
			// zero cell size puts every wall at the origin
			'{STEP_REG, REG_CELL_SIZE, 15'd0, '0, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'd0, 16'd0, 15'd1}, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_REG, REG_WALL_HALF, 15'd0, '0, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'd0, 16'd0, 15'd0}, CHK_MODEL, 1'b0, 1'b0},
			// empty grid
			'{STEP_REG, REG_MAP_WIDTH, 15'd0, '0, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'd0, 16'd0, 15'h7FFF}, CHK_FIXED, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd0, 6'd0, 8'd1, 16'd0, 16'd0, 15'd0}, CHK_FIXED, 1'b0, 1'b0},
			// oversized grid and the largest cell and box
			'{STEP_REG, REG_MAP_WIDTH, 15'd127, '0, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_REG, REG_MAP_HEIGHT, 15'd127, '0, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_REG, REG_CELL_SIZE, 15'h7FFF, '0, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_REG, REG_WALL_HALF, 15'h7FFF, '0, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'd0, 16'd0, 15'h7FFF}, CHK_MODEL, 1'b0, 1'b0},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_WRITE, 6'd63, 6'd0, 8'd1, 16'd0, 16'd0, 15'd0}, CHK_FIXED, 1'b0, 1'b1},
			'{STEP_ITEM, REG_MAP_WIDTH, 15'd0,
				'{OP_QUERY, 6'd0, 6'd0, 8'd0, 16'h8000, 16'h8000, 15'd0}, CHK_MODEL, 1'b0, 1'b0}
		};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (i = 0; i < DIRECTED_STEPS; i++) begin
			st = directed_steps[i];
			if (st.kind == STEP_REG) begin
				wait_idle();
				program_reg(st.ridx, 32'(st.rval));
			end else begin
				fixed.hit      = st.hit;
				fixed.write_ok = st.wok;
				push_item(st.it, 0, st.chk, fixed);
			end
		end

		// random phases, each with its own grid setting
		for (p = 0; p < RAND_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin w_reg = 1; h_reg = 1; end
				1: begin w_reg = 64; h_reg = 1; end
				2: begin w_reg = 1; h_reg = 64; end
				3: begin w_reg = 64; h_reg = 64; end
				4: begin w_reg = $urandom_range(65, 127); h_reg = $urandom_range(0, 3); end
				default: begin w_reg = $urandom_range(1, 12); h_reg = $urandom_range(1, 12); end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 70)
				cs_reg = $urandom_range(64, 512);
			else if (pick < 80)
				cs_reg = 1;
			else if (pick < 90)
				cs_reg = 32767;
			else
				cs_reg = $urandom_range(0, 32767);
			pick = $urandom_range(0, 99);
			if (pick < 60)
				bh_reg = $urandom_range(0, 256);
			else if (pick < 70)
				bh_reg = 0;
			else if (pick < 80)
				bh_reg = 32767;
			else
				bh_reg = $urandom_range(0, 32767);
			program_reg(REG_MAP_WIDTH, 32'(w_reg));
			program_reg(REG_MAP_HEIGHT, 32'(h_reg));
			program_reg(REG_CELL_SIZE, 32'(cs_reg));
			program_reg(REG_WALL_HALF, 32'(bh_reg));

			ew      = eff_dim(regs_shadow.map_width, GRID_COLS);
			eh      = eff_dim(regs_shadow.map_height, GRID_ROWS);
			cs      = longint'(regs_shadow.cell_size);
			big     = (ew * eh > BIG_GRID_CELLS);
			calm    = (p % 3 == 2);
			queries = 0;

			for (n = 0; n < PHASE_ITEMS; n++) begin
				// noise in every field, then shape the ones that matter
				it.op    = 1'($urandom_range(0, 1));
				it.col   = 6'($urandom_range(0, 63));
				it.row   = 6'($urandom_range(0, 63));
				it.code  = 8'($urandom_range(0, 255));
				it.qx    = 16'($urandom);
				it.qz    = 16'($urandom);
				it.qhalf = 15'($urandom);
				pick     = $urandom_range(0, 99);
				if (n < 4 || pick < 45 || (big && queries >= BIG_GRID_QUERIES)) begin
					// wall placement, mostly inside the grid
					it.op = OP_WRITE;
					if (ew > 0 && eh > 0 && $urandom_range(0, 9) < 8) begin
						it.col = 6'($urandom_range(0, ew - 1));
						it.row = 6'($urandom_range(0, eh - 1));
					end
					case ($urandom_range(0, 9)) inside
						[0:5]: it.code = WALL_CODE;
						[6:7]: it.code = '0;
						default: ;
					endcase
				end else begin
					it.op = OP_QUERY;
					queries++;
					if (pick < 85 && ew > 0 && eh > 0) begin
						// aim near a cell centre so both edges of the overlap show up
						if ($urandom_range(0, 4) != 0)
							it.qhalf = 15'($urandom_range(0, 600));
						tc  = $urandom_range(0, ew - 1);
						tr  = $urandom_range(0, eh - 1);
						lim = longint'(it.qhalf) + longint'(regs_shadow.wall_half);
						cx  = ((2 * longint'(tc) + 1 - longint'(ew)) * cs) / 2;
						cz  = -(((2 * longint'(tr) + 1 - longint'(eh)) * cs) / 2);
						it.qx = clamp16(cx + longint'($urandom_range(0, 2 * lim + 2)) - lim - 1);
						it.qz = clamp16(cz + longint'($urandom_range(0, 2 * lim + 2)) - lim - 1);
					end
				end
				push_item(it, calm ? 0 : pick_gap(), CHK_MODEL, '0);
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
src/tmbc_pkg.sv
src/tmbc_ram.sv
src/tmbc_datapath.sv
src/tmbc_ctrl.sv
src/tile_map_box_collision.sv
tb/sv/tile_map_box_collision_tb.sv
